### sv/h2r_pkg.sv
// shared constants and types for the hls to rgb converter
package h2r_pkg;

    localparam int HUE_W  = 12;
    localparam int Q12_W  = 13;
    localparam int FACT_W = 12;

    localparam logic [Q12_W-1:0] ONE_Q12  = 13'd4096;
    localparam logic [Q12_W-1:0] HALF_Q12 = 13'd2048;
    localparam logic [HUE_W-1:0] THIRD_Q12      = 12'd1365;
    localparam logic [HUE_W-1:0] TWO_THIRDS_Q12 = 12'd2730;
    // hue offset for blue: one turn minus a third, taken modulo one turn
    localparam logic [HUE_W-1:0] BLUE_OFS_Q12   = 12'd2731;

    // segment boundaries of the hue ramp (first hue outside each segment)
    localparam logic [HUE_W-1:0] RISE_END = 12'd683;
    localparam logic [HUE_W-1:0] HIGH_END = 12'd2048;
    localparam logic [HUE_W-1:0] FALL_END = 12'd2731;

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } ramp_seg_t;

    // advance enables for the channel stages
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

### sv/h2r_chan.sv
// three-stage hue ramp evaluation for one color channel
module h2r_chan
    import h2r_pkg::*;
(
    input  logic             clk,
    input  stage_en_t        en,
    input  logic [HUE_W-1:0] hue,
    input  logic [Q12_W-1:0] span,
    input  logic [Q12_W-1:0] lo,
    input  logic [Q12_W-1:0] hi,
    output logic [Q12_W-1:0] value
);

    ramp_seg_t             seg3_reg, seg3_next;
    logic [FACT_W-1:0]     fact3_reg, fact3_next;
    ramp_seg_t             seg4_reg;
    logic [Q12_W-1:0]      ofs4_reg;
    logic [Q12_W+FACT_W-1:0] prod4;
    logic [Q12_W-1:0]      value5_reg, value5_next;
    logic [HUE_W+2:0]      six_h;
    logic [HUE_W+2:0]      six_fall;
    logic [HUE_W-1:0]      fall_dist;
    logic [Q12_W:0]        sum5;

    // segment select and ramp factor
    always_comb
    begin
        fall_dist = TWO_THIRDS_Q12 - hue;
        six_h     = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
        six_fall  = {1'b0, fall_dist, 2'b00} + {2'b00, fall_dist, 1'b0};
        if (hue < RISE_END)
        begin
            seg3_next  = SEG_RISE;
            fact3_next = six_h[FACT_W-1:0];
        end
        else if (hue < HIGH_END)
        begin
            seg3_next  = SEG_HIGH;
            fact3_next = '0;
        end
        else if (hue < FALL_END)
        begin
            seg3_next  = SEG_FALL;
            fact3_next = six_fall[FACT_W-1:0];
        end
        else
        begin
            seg3_next  = SEG_LOW;
            fact3_next = '0;
        end
    end

    assign prod4 = span * fact3_reg;

    always_comb
    begin
        sum5 = {1'b0, lo} + {1'b0, ofs4_reg};
        case (seg4_reg)
            SEG_HIGH: value5_next = hi;
            SEG_LOW:  value5_next = lo;
            default:  value5_next = sum5[Q12_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            seg3_reg  <= seg3_next;
            fact3_reg <= fact3_next;
        end
        if (en.s4)
        begin
            seg4_reg <= seg3_reg;
            ofs4_reg <= prod4[Q12_W+FACT_W-1:FACT_W];
        end
        if (en.s5)
        begin
            value5_reg <= value5_next;
        end
    end

    assign value = value5_reg;

endmodule

### sv/hls_to_rgb_convert.sv
// top level of the hls to rgb converter: five-stage pipeline with stream ports
// Converts hue in unsigned Q0.12 and lightness and saturation in unsigned Q1.12
// to red, green and blue in Q1.12 (4096 means 1.0). Hue is a fraction of a full
// turn and wraps; lightness and saturation above 4096 are clamped to 4096. The
// block accepts one beat per clock while s_axis_tready is high, and results
// leave on m_axis in input order. The five register stages, the first of which
// captures the beat, are: input clamp and hue offsets, the lightness by
// saturation multiply, the m1/m2 span and per-channel ramp segment select, the
// per-channel span by ramp multiply, and the final add or select into the
// output register. Each stage holds a valid bit and advances when it is empty
// or the stage after it moves, so a stall on the output side fills bubbles
// before back-pressure reaches s_axis_tready, and a held result never blocks
// earlier stages that have room.
module hls_to_rgb_convert
    import h2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // hue[11:0], lightness[24:12], saturation[37:25]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // out_red[12:0], out_green[25:13], out_blue[38:26]
);

    // per-stage valid bits and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    stage_en_t chan_en;

    // stage 1: clamped inputs and the three channel hues
    logic [HUE_W-1:0] hue_r1_reg, hue_g1_reg, hue_b1_reg;
    logic [Q12_W-1:0] lgt1_reg, sat1_reg;
    logic [HUE_W-1:0] in_hue;
    logic [Q12_W-1:0] in_lgt, in_sat, lgt1_next, sat1_next;

    // stage 2: truncated lightness times saturation
    logic [HUE_W-1:0]     hue_r2_reg, hue_g2_reg, hue_b2_reg;
    logic [Q12_W-1:0]     lgt2_reg, sat2_reg, prod2_reg;
    logic [2*Q12_W-1:0]   prod1;

    // stage 3: m2 (hi), m1 (lo) and their difference
    logic [Q12_W-1:0] hi3_reg, lo3_reg, span3_reg;
    logic [Q12_W+1:0] hi3_next, lo3_next, span3_next;

    // stage 4: bounds carried beside the channel products
    logic [Q12_W-1:0] hi4_reg, lo4_reg;

    logic [Q12_W-1:0] red5, green5, blue5;

    assign in_hue = s_axis_tdata[11:0];
    assign in_lgt = s_axis_tdata[24:12];
    assign in_sat = s_axis_tdata[37:25];

    assign lgt1_next = (in_lgt > ONE_Q12) ? ONE_Q12 : in_lgt;
    assign sat1_next = (in_sat > ONE_Q12) ? ONE_Q12 : in_sat;

    // a stage moves when it is empty or its successor moves
    assign en5 = !v5_reg || m_axis_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    assign chan_en.s3 = en3;
    assign chan_en.s4 = en4;
    assign chan_en.s5 = en5;

    assign prod1 = lgt1_reg * sat1_reg;

    // m2 on either side of half lightness, then m1 = 2L - m2
    always_comb
    begin
        if (lgt2_reg <= HALF_Q12)
        begin
            hi3_next = {2'b00, lgt2_reg} + {2'b00, prod2_reg};
        end
        else
        begin
            hi3_next = {2'b00, lgt2_reg} + {2'b00, sat2_reg} - {2'b00, prod2_reg};
        end
        lo3_next   = {1'b0, lgt2_reg, 1'b0} - hi3_next;
        span3_next = hi3_next - lo3_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            hue_r1_reg <= in_hue + THIRD_Q12;
            hue_g1_reg <= in_hue;
            hue_b1_reg <= in_hue + BLUE_OFS_Q12;
            lgt1_reg   <= lgt1_next;
            sat1_reg   <= sat1_next;
        end
        if (en2)
        begin
            hue_r2_reg <= hue_r1_reg;
            hue_g2_reg <= hue_g1_reg;
            hue_b2_reg <= hue_b1_reg;
            lgt2_reg   <= lgt1_reg;
            sat2_reg   <= sat1_reg;
            prod2_reg  <= prod1[2*Q12_W-2:HUE_W];
        end
        if (en3)
        begin
            hi3_reg   <= hi3_next[Q12_W-1:0];
            lo3_reg   <= lo3_next[Q12_W-1:0];
            span3_reg <= span3_next[Q12_W-1:0];
        end
        if (en4)
        begin
            hi4_reg <= hi3_reg;
            lo4_reg <= lo3_reg;
        end
    end

    h2r_chan u_red
    (
        .clk   (clk),
        .en    (chan_en),
        .hue   (hue_r2_reg),
        .span  (span3_reg),
        .lo    (lo4_reg),
        .hi    (hi4_reg),
        .value (red5)
    );

    h2r_chan u_green
    (
        .clk   (clk),
        .en    (chan_en),
        .hue   (hue_g2_reg),
        .span  (span3_reg),
        .lo    (lo4_reg),
        .hi    (hi4_reg),
        .value (green5)
    );

    h2r_chan u_blue
    (
        .clk   (clk),
        .en    (chan_en),
        .hue   (hue_b2_reg),
        .span  (span3_reg),
        .lo    (lo4_reg),
        .hi    (hi4_reg),
        .value (blue5)
    );

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = {1'b0, blue5, green5, red5};

endmodule
